/* sv/mwm_pkg.sv */
// Mecanum wheel mixer package: widths, arithmetic constants, sequencer states
// and the multiply-accumulate control bundle. No dependencies.

package mwm_pkg;

	localparam int TRACK_PERIOD = 10;
	localparam int CNT_W        = 4;
	localparam int IN_W         = 11;
	localparam int OUT_W        = 13;
	localparam int LIM_W        = 12;
	localparam int GAIN_W       = 10;
	localparam int MID_W        = 24;
	localparam int COEF_W       = 18;
	localparam int OPND_W       = 34;
	localparam int ACC_W        = 46;
	localparam int DEN_W        = 33;
	localparam int QUOT_W       = 16;
	localparam int WIDX_W       = 2;
	localparam int STEP_W       = 3;

	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 56;
	localparam int M_USER_W = 1;

	localparam int GAIN_KNEE  = 100;
	localparam int HEAD_SMALL = 20;
	localparam int FULL_SCALE = 100000;
	localparam int LIMIT_RST  = 370;

	localparam logic signed [COEF_W-1:0] C_GAIN_DEN = COEF_W'(100);
	localparam logic signed [COEF_W-1:0] C_MIX      = COEF_W'(707);
	localparam logic signed [COEF_W-1:0] C_UNIT     = COEF_W'(1000);
	localparam logic signed [COEF_W-1:0] C_FULL     = COEF_W'(FULL_SCALE);

	localparam int CFG_ADDR_W = 2;
	localparam logic [CFG_ADDR_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GYRO   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_LIMIT  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MIX,
		ST_LIMIT,
		ST_CMP,
		ST_NUM,
		ST_DIVGO,
		ST_DIVRUN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                     en;
		logic                     clr;
		logic signed [COEF_W-1:0] coef;
	} mac_ctl_t;

endpackage

/* sv/mwm_mac.sv */
// Shared multiply-accumulate unit of the mecanum wheel mixer.
// Depends on mwm_pkg for widths and the control bundle.

module mwm_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mwm_pkg::mac_ctl_t                   ctl,
	input  logic signed [mwm_pkg::OPND_W-1:0]   opnd,
	output logic signed [mwm_pkg::ACC_W-1:0]    acc
);
	import mwm_pkg::*;

	logic signed [COEF_W+OPND_W-1:0] prod;
	logic signed [ACC_W-1:0]         base;
	logic signed [ACC_W-1:0]         acc_q;

	assign prod = $signed(ctl.coef) * opnd;
	assign base = ctl.clr ? '0 : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= base + $signed(prod[ACC_W-1:0]);
		end
	end

	assign acc = acc_q;

endmodule

/* sv/mwm_div.sv */
// Serial rounding divider of the mecanum wheel mixer: one quotient bit a cycle,
// round to nearest with ties away from zero, saturate to the wheel width.
// Depends on mwm_pkg for widths.

module mwm_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [mwm_pkg::ACC_W-1:0]   numer,
	input  logic        [mwm_pkg::DEN_W-1:0]   denom,
	output logic                               busy,
	output logic                               done,
	output logic signed [mwm_pkg::OUT_W-1:0]   quot
);
	import mwm_pkg::*;

	localparam int NUM_W  = ACC_W + 1;
	localparam int SH_W   = DEN_W + QUOT_W;
	localparam int QCNT_W = $clog2(QUOT_W);
	localparam int OUT_MAXV = 2 ** (OUT_W - 1) - 1;
	localparam int OUT_NEGM = 2 ** (OUT_W - 1);

	logic [ACC_W-1:0]        mag;
	logic [NUM_W-1:0]        rem_q, rem_nx;
	logic [SH_W-1:0]         dsh_q;
	logic [QUOT_W-1:0]       quo_q, quo_nx;
	logic [QCNT_W-1:0]       cnt_q;
	logic                    run_q, done_q, neg_q, fits;
	logic signed [OUT_W-1:0] quot_q;

	function automatic logic signed [OUT_W-1:0] sat_q(input logic [QUOT_W-1:0] q,
			input logic neg);
		logic [QUOT_W-1:0] nq;
		nq = -q;
		if (neg) begin
			sat_q = (q > QUOT_W'(OUT_NEGM)) ? OUT_W'(OUT_NEGM) : nq[OUT_W-1:0];
		end else begin
			sat_q = (q > QUOT_W'(OUT_MAXV)) ? OUT_W'(OUT_MAXV) : q[OUT_W-1:0];
		end
	endfunction

	assign mag    = numer[ACC_W-1] ? ACC_W'(-numer) : ACC_W'(numer);
	assign fits   = SH_W'(rem_q) >= dsh_q;
	assign rem_nx = fits ? rem_q - dsh_q[NUM_W-1:0] : rem_q;
	assign quo_nx = {quo_q[QUOT_W-2:0], fits};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && !start && (cnt_q == '0);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= QCNT_W'(QUOT_W - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {mag, 1'b0} + NUM_W'(denom);
			dsh_q <= SH_W'({denom, 1'b0}) << (QUOT_W - 1);
			quo_q <= '0;
			neg_q <= numer[ACC_W-1];
		end else if (run_q) begin
			rem_q <= rem_nx;
			dsh_q <= dsh_q >> 1;
			quo_q <= quo_nx;
			if (cnt_q == '0) begin
				quot_q <= sat_q(quo_nx, neg_q);
			end
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign quot = quot_q;

endmodule

/* sv/mecanum_wheel_mixer_top.sv */
// Mecanum wheel mixer top level: sequencer, held state, configuration and ports.
// Depends on mwm_pkg, mwm_mac and mwm_div.
//
// channel  | dir | handshake                    | payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: six 11-bit signed command fields
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: four 13-bit wheels, tuser: was_scaled
// cfg      | in  | cfg_we (no wait)             | cfg_addr, cfg_wdata (12 bits)
//
// In an enabled tick the serial divider, run 16 steps for each of the four wheels,
// takes most of the time from transfer to result.
// A tick while disabled is taken and dropped.
// The input side is ready only while the sequencer is idle; a finished result
// waits in the output register, and the next result holds until it drains.

module mecanum_wheel_mixer_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mwm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [mwm_pkg::LIM_W-1:0]            cfg_wdata,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// cmd_x, cmd_y, cmd_rot, track_fwd_error, track_side_error, heading_correction
	input  logic [mwm_pkg::S_DATA_W-1:0]         s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// wheel_front_left, wheel_front_right, wheel_rear_left, wheel_rear_right
	output logic [mwm_pkg::M_DATA_W-1:0]         m_axis_tdata,
	// was_scaled
	output logic [mwm_pkg::M_USER_W-1:0]         m_axis_tuser
);
	import mwm_pkg::*;

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [WIDX_W-1:0] widx_q, widx_d, tidx;

	logic en_q, gyro_q;
	logic [LIM_W-1:0] lim_q;

	logic [CNT_W-1:0] tick_q;
	logic [CNT_W:0]   tick_nx;
	logic signed [IN_W-1:0] tf_q, ts_q;

	logic signed [IN_W-1:0] in_x, in_y, in_r, in_tf, in_ts, in_hc, mn;
	logic [GAIN_W-1:0] gain;
	logic signed [IN_W:0] h2;

	logic signed [IN_W-1:0] x_q, y_q, r_q;
	logic signed [IN_W:0]   h2_q, ntf, nts;
	logic [GAIN_W-1:0]      g_q;
	logic signed [MID_W-1:0] xm_q, ym_q, wm_q;
	logic signed [OPND_W-1:0] t_q [4];
	logic signed [OPND_W-1:0] mx_q;
	logic scaled_q;
	logic signed [OUT_W-1:0] wh_q [4];

	mac_ctl_t mctl;
	logic signed [OPND_W-1:0] mopnd;
	logic signed [ACC_W-1:0]  acc;

	logic div_go, div_busy, div_done;
	logic signed [ACC_W-1:0] div_n;
	logic [DEN_W-1:0]        div_d;
	logic signed [OUT_W-1:0] div_q;

	logic cap_x, cap_y, cap_w, cap_t, wheel_we, emit, take;
	logic pos_x, pos_y;

	logic m_valid_q;
	logic [M_DATA_W-1:0] mdata_q;
	logic [M_USER_W-1:0] muser_q;

	assign in_x  = s_axis_tdata[0*IN_W +: IN_W];
	assign in_y  = s_axis_tdata[1*IN_W +: IN_W];
	assign in_r  = s_axis_tdata[2*IN_W +: IN_W];
	assign in_tf = s_axis_tdata[3*IN_W +: IN_W];
	assign in_ts = s_axis_tdata[4*IN_W +: IN_W];
	assign in_hc = s_axis_tdata[5*IN_W +: IN_W];

	always_comb begin
		mn = in_x;
		if (in_y < mn) begin
			mn = in_y;
		end
		if (in_r < mn) begin
			mn = in_r;
		end
	end

	assign gain    = (mn > GAIN_KNEE) ? mn[GAIN_W-1:0] : GAIN_W'(GAIN_KNEE);
	assign h2      = (in_hc < HEAD_SMALL) ? {in_hc, 1'b0} : {in_hc[IN_W-1], in_hc};
	assign tick_nx = {1'b0, tick_q} + 1'b1;
	assign ntf     = -(IN_W+1)'(tf_q);
	assign nts     = -(IN_W+1)'(ts_q);
	assign take    = s_axis_tvalid && s_axis_tready;
	assign pos_x   = (widx_q == 2'd0) || (widx_q == 2'd1);
	assign pos_y   = (widx_q == 2'd0) || (widx_q == 2'd2);
	assign tidx    = (state_q == ST_LIMIT) ? 2'd3 : widx_q - 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			gyro_q <= 1'b0;
			lim_q  <= LIM_W'(LIMIT_RST);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ENABLE: en_q   <= cfg_wdata[0];
				REG_GYRO:   gyro_q <= cfg_wdata[0];
				REG_LIMIT:  lim_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			widx_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			widx_q  <= widx_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		step_d        = step_q;
		widx_d        = widx_q;
		mctl          = '0;
		mopnd         = '0;
		div_go        = 1'b0;
		cap_x         = 1'b0;
		cap_y         = 1'b0;
		cap_w         = 1'b0;
		cap_t         = 1'b0;
		wheel_we      = 1'b0;
		emit          = 1'b0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && en_q) begin
					state_d = ST_PREP;
					step_d  = '0;
				end
			end
			ST_PREP: begin
				mctl.en = 1'b1;
				step_d  = step_q + 1'b1;
				unique case (step_q)
					3'd0: begin
						mctl.clr  = 1'b1;
						mctl.coef = C_GAIN_DEN;
						mopnd     = OPND_W'(x_q);
					end
					3'd1: begin
						mctl.coef = COEF_W'(g_q);
						mopnd     = gyro_q ? OPND_W'(ntf) : '0;
					end
					3'd2: begin
						cap_x     = 1'b1;
						mctl.clr  = 1'b1;
						mctl.coef = C_GAIN_DEN;
						mopnd     = OPND_W'(y_q);
					end
					3'd3: begin
						mctl.coef = COEF_W'(g_q);
						mopnd     = gyro_q ? OPND_W'(nts) : '0;
					end
					3'd4: begin
						cap_y     = 1'b1;
						mctl.clr  = 1'b1;
						mctl.coef = C_GAIN_DEN;
						mopnd     = OPND_W'(r_q);
					end
					3'd5: begin
						mctl.coef = COEF_W'(g_q);
						mopnd     = gyro_q ? OPND_W'(h2_q) : OPND_W'(ntf);
					end
					default: begin
						mctl.coef = COEF_W'(g_q);
						mopnd     = gyro_q ? '0 : OPND_W'(nts);
						state_d   = ST_MIX;
						step_d    = '0;
						widx_d    = '0;
					end
				endcase
			end
			ST_MIX: begin
				mctl.en = 1'b1;
				step_d  = step_q + 1'b1;
				unique case (step_q)
					3'd0: begin
						cap_w     = (widx_q == 2'd0);
						cap_t     = (widx_q != 2'd0);
						mctl.clr  = 1'b1;
						mctl.coef = pos_x ? C_MIX : -C_MIX;
						mopnd     = OPND_W'(xm_q);
					end
					3'd1: begin
						mctl.coef = pos_y ? C_MIX : -C_MIX;
						mopnd     = OPND_W'(ym_q);
					end
					default: begin
						mctl.coef = -C_UNIT;
						mopnd     = OPND_W'(wm_q);
						step_d    = '0;
						if (widx_q == 2'd3) begin
							state_d = ST_LIMIT;
						end else begin
							widx_d = widx_q + 1'b1;
						end
					end
				endcase
			end
			ST_LIMIT: begin
				cap_t     = 1'b1;
				mctl.en   = 1'b1;
				mctl.clr  = 1'b1;
				mctl.coef = C_FULL;
				mopnd     = OPND_W'(lim_q);
				state_d   = ST_CMP;
			end
			ST_CMP: begin
				state_d = ST_NUM;
				widx_d  = '0;
			end
			ST_NUM: begin
				mctl.en   = 1'b1;
				mctl.clr  = 1'b1;
				mctl.coef = COEF_W'(lim_q);
				mopnd     = t_q[widx_q];
				state_d   = ST_DIVGO;
			end
			ST_DIVGO: begin
				div_go  = 1'b1;
				state_d = ST_DIVRUN;
			end
			ST_DIVRUN: begin
				if (div_done) begin
					wheel_we = 1'b1;
					if (widx_q == 2'd3) begin
						state_d = ST_EMIT;
					end else begin
						widx_d  = widx_q + 1'b1;
						state_d = ST_NUM;
					end
				end
			end
			ST_EMIT: begin
				if (!m_valid_q || m_axis_tready) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			tf_q   <= '0;
			ts_q   <= '0;
		end else if (take && en_q) begin
			if (tick_nx >= (CNT_W+1)'(TRACK_PERIOD)) begin
				tick_q <= '0;
				tf_q   <= in_tf;
				ts_q   <= in_ts;
			end else begin
				tick_q <= tick_nx[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mx_q <= '0;
		end else if (take) begin
			mx_q <= '0;
		end else if (cap_t && ($signed(acc[OPND_W-1:0]) > mx_q)) begin
			mx_q <= acc[OPND_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_q  <= in_x;
			y_q  <= in_y;
			r_q  <= in_r;
			h2_q <= h2;
			g_q  <= gain;
		end
		if (cap_x) begin
			xm_q <= acc[MID_W-1:0];
		end
		if (cap_y) begin
			ym_q <= acc[MID_W-1:0];
		end
		if (cap_w) begin
			wm_q <= acc[MID_W-1:0];
		end
		if (cap_t) begin
			t_q[tidx] <= acc[OPND_W-1:0];
		end
		if (state_q == ST_CMP) begin
			scaled_q <= ACC_W'(mx_q) > acc;
		end
		if (wheel_we) begin
			wh_q[widx_q] <= div_q;
		end
	end

	assign div_n = scaled_q ? acc : ACC_W'(t_q[widx_q]);
	assign div_d = scaled_q ? mx_q[DEN_W-1:0] : DEN_W'(FULL_SCALE);

	mwm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.opnd   (mopnd),
		.acc    (acc)
	);

	mwm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.numer  (div_n),
		.denom  (div_d),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			mdata_q <= {(M_DATA_W-4*OUT_W)'(0), wh_q[3], wh_q[2], wh_q[1], wh_q[0]};
			muser_q <= M_USER_W'(scaled_q);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = mdata_q;
	assign m_axis_tuser  = muser_q;

	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q < CNT_W'(TRACK_PERIOD))
		else $error("tick counter beyond track period");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> !div_busy)
		else $error("divider started while busy");

	a_max_sign: assert property (@(posedge clk) disable iff (!arst_n)
		!mx_q[OPND_W-1])
		else $error("largest target went negative");

	a_scaled_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
		($signed(m_axis_tdata[0*OUT_W +: OUT_W]) <= $signed({1'b0, lim_q}) &&
		 $signed(m_axis_tdata[1*OUT_W +: OUT_W]) <= $signed({1'b0, lim_q}) &&
		 $signed(m_axis_tdata[2*OUT_W +: OUT_W]) <= $signed({1'b0, lim_q}) &&
		 $signed(m_axis_tdata[3*OUT_W +: OUT_W]) <= $signed({1'b0, lim_q})))
		else $error("scaled wheel above speed limit");

endmodule
